[hdl/mi3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants and types for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

   // arithmetic runs modulo 2^64, quotient is 32 bits, determinant out is 51
   localparam int ARITH_BITS = 64;
   localparam int QUOT_BITS  = 32;
   localparam int DET_BITS   = 51;
   localparam int OUT_FRAC   = 16;
   localparam int NUM_ELEM   = 9;

   localparam logic [QUOT_BITS-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [QUOT_BITS-1:0] NEG_MAX = 32'h8000_0000;

   // cofactor k = a[p]*a[q] - a[r]*a[s], a indexed row*3+column
   localparam int COF_IDX [NUM_ELEM][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   // one divider lane: partial remainder and dividend/quotient shift word
   typedef struct packed {
      logic [ARITH_BITS-1:0] rem;
      logic [QUOT_BITS-1:0]  qs;
   } div_lane_type;

   // payload of one divider stage
   typedef struct packed {
      logic [ARITH_BITS-1:0]          dmag;
      logic                           singular;
      logic [DET_BITS-1:0]            det;
      logic [NUM_ELEM-1:0]            neg;
      logic [NUM_ELEM-1:0]            ovf;
      div_lane_type [NUM_ELEM-1:0]    lane;
   } div_stage_type;

endpackage
`default_nettype wire

[hdl/matrix_inverse_3x3.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a 3x3 fixed-point matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: nine signed elements req_r0c0..req_r2c2 (ELEM_BITS wide,
//   ELEM_BITS/2 fraction bits), taken at a rising edge with start high and
//   busy low. busy is always low: a new matrix may enter every cycle.
//   Result word: nine signed Q16.16 inverse elements, the Q27.24 determinant,
//   singular and saturated flags, shown for one cycle with rsp_valid high.
//   The receiver has no back-pressure; every result must be taken.
//   Throughput: one matrix per cycle. The depth is set by the 32-stage
//   restoring divider (one quotient bit per stage, nine lanes side by side)
//   behind five stages of products, cofactors, determinant and magnitude.
//   A zero determinant gives zero elements and singular high.
//   Reset clears only the valid bits of the pipeline; data in flight is
//   dropped and no result appears for it.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
   parameter int ELEM_BITS = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire signed [ELEM_BITS-1:0] req_r0c0,
   input  wire signed [ELEM_BITS-1:0] req_r0c1,
   input  wire signed [ELEM_BITS-1:0] req_r0c2,
   input  wire signed [ELEM_BITS-1:0] req_r1c0,
   input  wire signed [ELEM_BITS-1:0] req_r1c1,
   input  wire signed [ELEM_BITS-1:0] req_r1c2,
   input  wire signed [ELEM_BITS-1:0] req_r2c0,
   input  wire signed [ELEM_BITS-1:0] req_r2c1,
   input  wire signed [ELEM_BITS-1:0] req_r2c2,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_inv_r0c0,
   output logic signed [31:0]       rsp_inv_r0c1,
   output logic signed [31:0]       rsp_inv_r0c2,
   output logic signed [31:0]       rsp_inv_r1c0,
   output logic signed [31:0]       rsp_inv_r1c1,
   output logic signed [31:0]       rsp_inv_r1c2,
   output logic signed [31:0]       rsp_inv_r2c0,
   output logic signed [31:0]       rsp_inv_r2c1,
   output logic signed [31:0]       rsp_inv_r2c2,
   output logic signed [50:0]       rsp_determinant,
   output logic                     rsp_singular,
   output logic                     rsp_saturated
);

   localparam int NE     = mi3_pkg::NUM_ELEM;
   localparam int AW     = mi3_pkg::ARITH_BITS;
   localparam int QW     = mi3_pkg::QUOT_BITS;
   localparam int DW     = mi3_pkg::DET_BITS;
   localparam int PROD_W = 2 * ELEM_BITS;
   localparam int COF_W  = 2 * ELEM_BITS + 1;
   localparam int TRI_W  = 3 * ELEM_BITS + 1;
   localparam int SUM_W  = 3 * ELEM_BITS + 3;
   localparam int SHIFT  = ELEM_BITS / 2 + mi3_pkg::OUT_FRAC;

   assign busy = 1'b0;

   // stage 1: input word register
   logic                        s1_vld_ff;
   logic signed [ELEM_BITS-1:0] a_ff [NE];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start;
      end
      a_ff[0] <= req_r0c0;
      a_ff[1] <= req_r0c1;
      a_ff[2] <= req_r0c2;
      a_ff[3] <= req_r1c0;
      a_ff[4] <= req_r1c1;
      a_ff[5] <= req_r1c2;
      a_ff[6] <= req_r2c0;
      a_ff[7] <= req_r2c1;
      a_ff[8] <= req_r2c2;
   end

   // stage 2: nine cofactors, first row carried for the determinant
   logic                        s2_vld_ff;
   logic signed [COF_W-1:0]     cof_ff [NE];
   logic signed [COF_W-1:0]     cof_in [NE];
   logic signed [ELEM_BITS-1:0] row0_ff [3];

   for (genvar k = 0; k < NE; k++) begin : g_cof
      logic signed [PROD_W-1:0] p_pos;
      logic signed [PROD_W-1:0] p_neg;
      assign p_pos = a_ff[mi3_pkg::COF_IDX[k][0]] * a_ff[mi3_pkg::COF_IDX[k][1]];
      assign p_neg = a_ff[mi3_pkg::COF_IDX[k][2]] * a_ff[mi3_pkg::COF_IDX[k][3]];
      assign cof_in[k] = COF_W'(p_pos) - COF_W'(p_neg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      cof_ff     <= cof_in;
      row0_ff[0] <= a_ff[0];
      row0_ff[1] <= a_ff[1];
      row0_ff[2] <= a_ff[2];
   end

   // stage 3: first-row expansion terms of the determinant
   logic                    s3_vld_ff;
   logic signed [TRI_W-1:0] tri_ff [3];
   logic signed [TRI_W-1:0] tri_in [3];
   logic signed [COF_W-1:0] cof3_ff [NE];

   assign tri_in[0] = row0_ff[0] * cof_ff[0];
   assign tri_in[1] = row0_ff[1] * cof_ff[3];
   assign tri_in[2] = row0_ff[2] * cof_ff[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      tri_ff  <= tri_in;
      cof3_ff <= cof_ff;
   end

   // stage 4: determinant (modulo 2^64) and shifted cofactor magnitudes
   logic                 s4_vld_ff;
   logic signed [SUM_W-1:0] det_sum;
   logic [AW-1:0]        det_ff;
   logic [AW-1:0]        dvd_ff [NE];
   logic [AW-1:0]        dvd_in [NE];
   logic [NE-1:0]        cneg_ff;
   logic [NE-1:0]        cneg_in;

   assign det_sum = SUM_W'(tri_ff[0]) + SUM_W'(tri_ff[1]) + SUM_W'(tri_ff[2]);

   for (genvar k = 0; k < NE; k++) begin : g_mag
      logic signed [AW-1:0] c64;
      logic [AW-1:0]        cmag;
      assign c64        = AW'(cof3_ff[k]);
      assign cneg_in[k] = cof3_ff[k][COF_W-1];
      assign cmag       = cneg_in[k] ? AW'(-c64) : AW'(c64);
      assign dvd_in[k]  = cmag << SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      det_ff  <= AW'(det_sum);
      dvd_ff  <= dvd_in;
      cneg_ff <= cneg_in;
   end

   // stage 5: divisor magnitude, overflow check, divider setup
   logic                   div_vld_ff [QW+1];
   mi3_pkg::div_stage_type div_ff     [QW+1];
   mi3_pkg::div_stage_type div0_in;

   always_comb begin
      logic          dneg;
      logic [AW-1:0] dmag;
      dneg = det_ff[AW-1];
      dmag = dneg ? AW'(-det_ff) : det_ff;
      div0_in.dmag     = dmag;
      div0_in.singular = (det_ff == '0);
      div0_in.det      = det_ff[DW-1:0];
      for (int k = 0; k < NE; k++) begin
         div0_in.neg[k]      = cneg_ff[k] ^ dneg;
         // quotient would need more than 32 bits
         div0_in.ovf[k]      = {{QW{1'b0}}, dvd_ff[k]} >= {dmag, {QW{1'b0}}};
         div0_in.lane[k].rem = AW'(dvd_ff[k][AW-1:QW]);
         div0_in.lane[k].qs  = dvd_ff[k][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else begin
         div_vld_ff[0] <= s4_vld_ff;
      end
      div_ff[0] <= div0_in;
   end

   // divider: one restoring step per stage on all nine lanes
   for (genvar s = 0; s < QW; s++) begin : g_div
      mi3_pkg::div_stage_type step_in;

      always_comb begin
         logic [AW:0] r2;
         logic        ge;
         step_in = div_ff[s];
         for (int k = 0; k < NE; k++) begin
            r2 = {div_ff[s].lane[k].rem, div_ff[s].lane[k].qs[QW-1]};
            ge = r2 >= {1'b0, div_ff[s].dmag};
            if (ge) begin
               r2 = r2 - {1'b0, div_ff[s].dmag};
            end
            step_in.lane[k].rem = r2[AW-1:0];
            step_in.lane[k].qs  = {div_ff[s].lane[k].qs[QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[s+1] <= 1'b0;
         end else begin
            div_vld_ff[s+1] <= div_vld_ff[s];
         end
         div_ff[s+1] <= step_in;
      end
   end

   // output stage: sign, saturation, singular override
   logic                 out_vld_ff;
   logic [QW-1:0]        inv_ff [NE];
   logic [QW-1:0]        inv_in [NE];
   logic [DW-1:0]        det_out_ff;
   logic                 sing_ff;
   logic                 sat_ff;
   logic                 sat_in;

   always_comb begin
      logic [QW-1:0] q;
      logic          clip;
      sat_in = 1'b0;
      for (int k = 0; k < NE; k++) begin
         q = div_ff[QW].lane[k].qs;
         if (div_ff[QW].neg[k]) begin
            clip = div_ff[QW].ovf[k] || (q > mi3_pkg::NEG_MAX);
            if (clip) begin
               q = mi3_pkg::NEG_MAX;
            end
            q = -q;
         end else begin
            clip = div_ff[QW].ovf[k] || (q > mi3_pkg::POS_MAX);
            if (clip) begin
               q = mi3_pkg::POS_MAX;
            end
         end
         sat_in    = sat_in | clip;
         inv_in[k] = div_ff[QW].singular ? '0 : q;
      end
      if (div_ff[QW].singular) begin
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= div_vld_ff[QW];
      end
      inv_ff     <= inv_in;
      det_out_ff <= div_ff[QW].det;
      sing_ff    <= div_ff[QW].singular;
      sat_ff     <= sat_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_inv_r0c0    = inv_ff[0];
   assign rsp_inv_r0c1    = inv_ff[1];
   assign rsp_inv_r0c2    = inv_ff[2];
   assign rsp_inv_r1c0    = inv_ff[3];
   assign rsp_inv_r1c1    = inv_ff[4];
   assign rsp_inv_r1c2    = inv_ff[5];
   assign rsp_inv_r2c0    = inv_ff[6];
   assign rsp_inv_r2c1    = inv_ff[7];
   assign rsp_inv_r2c2    = inv_ff[8];
   assign rsp_determinant = det_out_ff;
   assign rsp_singular    = sing_ff;
   assign rsp_saturated   = sat_ff;

endmodule
`default_nettype wire
